// ===== sv/pcsf_pkg.sv =====
package pcsf_pkg;

  localparam logic [15:0] FILL_HALF  = 16'hC000;
  localparam logic [1:0]  HEADER_TAG = 2'b01;
  localparam logic [1:0]  HIT_TAG    = 2'b10;
  localparam logic [11:0] COUNT_MAX  = 12'hFFF;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHIP_LOW   = 2'd0,
    REG_CHIP_HIGH  = 2'd1,
    REG_HALF_STAVE = 2'd2,
    REG_FO_MASK    = 2'd3
  } cfg_reg_t;

  // Which word the output register loads.
  typedef enum logic [1:0] {
    SEL_TRL = 2'd0,
    SEL_EMP = 2'd1,
    SEL_HIT = 2'd2
  } word_sel_t;

  typedef struct packed {
    logic      load;
    logic      emit;
    word_sel_t sel;
  } dp_cmd_t;

  typedef struct packed {
    logic plan_trl;
    logic plan_emp;
    logic plan_hit;
    logic emp_r;
    logic hit_r;
    logic emp_last;
    logic out_free;
  } dp_stat_t;

  function automatic logic [15:0] header_half(input logic [2:0] hs, input logic [3:0] ch);
    return {HEADER_TAG, hs, 7'b0, ch};
  endfunction

endpackage

// ===== sv/pcsf_if.sv =====
interface pcsf_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [3:0] chip;
  logic [4:0] col;
  logic [7:0] row;

  modport source (output valid, cmd, chip, col, row, input ready);
  modport sink   (input valid, cmd, chip, col, row, output ready);
endinterface

interface pcsf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] word;
  logic        last;

  modport source (output valid, word, last, input ready);
  modport sink   (input valid, word, last, output ready);
endinterface

// ===== sv/pixel_chip_stream_framer.sv =====
// An item is taken only while the sequencer is idle; the words it causes are played out
// one after another (0 to 16: trailer, empty chips, hit word), one word per cycle while the
// output drains, and the next item is accepted only after the last of them is loaded.
// The pace is set by the single output register, which the sequencer fills one word at a time.
// Reset (rst_n low at a clock edge, synchronous) restores the register defaults
// and closes the module: no chip open, no count, no pending half, no word held.
module pixel_chip_stream_framer
  import pcsf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  pcsf_in_if.sink               in_ch,
  pcsf_out_if.source            out_ch
);

  // The controller walks the words an item causes: the trailer of the chip
  // that closes, the empty chips in the gap, then the word that pairs an
  // upper half with the new hit. The datapath decides that plan when the
  // item is taken and updates the module state at once.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  pcsf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath also holds the configuration registers and the output
  // register, so a finished word can wait while the next item is taken.
  pcsf_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .in_cmd    (in_ch.cmd),
    .in_chip   (in_ch.chip),
    .in_col    (in_ch.col),
    .in_row    (in_ch.row),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_word  (out_ch.word),
    .out_last  (out_ch.last)
  );

endmodule

// ===== sv/pcsf_dpath.sv =====
module pcsf_dpath
  import pcsf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_cmd,
  input  logic [3:0]            in_chip,
  input  logic [4:0]            in_col,
  input  logic [7:0]            in_row,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           out_word,
  output logic                  out_last
);

  logic [3:0]  chip_low_r, chip_high_r;
  logic [2:0]  hs_r;
  logic [15:0] fo_mask_r;

  logic [3:0]  prev_r;
  logic        open_r;
  logic [11:0] count_r;
  logic [15:0] pend_r;
  logic        pend_vld_r;

  logic [31:0] trl_word_r, hit_word_r;
  logic [4:0]  cur_r, stop_r;
  logic        emp_r, hit_r;

  logic        out_valid_r, out_last_r;
  logic [31:0] out_word_r;

  logic [15:0] hit_half;
  logic        new_chip, ignore;
  logic [4:0]  start, stop_nxt;
  logic [11:0] count_inc;
  logic [31:0] trl_word_nxt, hit_word_nxt, emp_word;
  logic        plan_trl, plan_emp, plan_hit;

  always_comb begin
    hit_half  = {HIT_TAG, 1'b0, in_row, in_col};
    new_chip  = !open_r || (in_chip > prev_r);
    ignore    = open_r ? (in_chip < prev_r) : (in_chip < chip_low_r);
    start     = open_r ? ({1'b0, prev_r} + 5'd1) : {1'b0, chip_low_r};
    stop_nxt  = in_cmd ? {1'b0, chip_high_r} : ({1'b0, in_chip} - 5'd1);
    count_inc = (count_r != COUNT_MAX) ? (count_r + 12'd1) : count_r;
    plan_trl  = open_r && (in_cmd || new_chip);
    plan_emp  = in_cmd ? ({1'b0, chip_high_r} >= start)
                       : (!ignore && new_chip && ({1'b0, in_chip} > start));
    plan_hit  = !in_cmd && !ignore && (new_chip || pend_vld_r);
    trl_word_nxt = {(pend_vld_r ? pend_r : FILL_HALF),
                    2'b00, fo_mask_r[prev_r], 1'b0, count_r};
    hit_word_nxt = {(new_chip ? header_half(hs_r, in_chip) : pend_r), hit_half};
    emp_word     = {header_half(hs_r, cur_r[3:0]), 2'b00, fo_mask_r[cur_r[3:0]], 13'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chip_low_r  <= 4'd0;
      chip_high_r <= 4'd4;
      hs_r        <= 3'd0;
      fo_mask_r   <= 16'd0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_CHIP_LOW:   chip_low_r  <= cfg_data[3:0];
        REG_CHIP_HIGH:  chip_high_r <= cfg_data[3:0];
        REG_HALF_STAVE: hs_r        <= cfg_data[2:0];
        REG_FO_MASK:    fo_mask_r   <= cfg_data;
      endcase
    end
  end

  // Module state is updated in full when the item is taken; the trailer and hit words
  // and the empty-chip range were captured at the same edge and are played out afterwards.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r     <= 4'd0;
      open_r     <= 1'b0;
      count_r    <= 12'd0;
      pend_r     <= 16'd0;
      pend_vld_r <= 1'b0;
    end else if (cmd.load) begin
      if (in_cmd) begin
        open_r     <= 1'b0;
        count_r    <= 12'd0;
        pend_r     <= 16'd0;
        pend_vld_r <= 1'b0;
      end else if (!ignore) begin
        if (new_chip) begin
          prev_r     <= in_chip;
          open_r     <= 1'b1;
          count_r    <= 12'd1;
          pend_r     <= 16'd0;
          pend_vld_r <= 1'b0;
        end else begin
          count_r <= count_inc;
          if (pend_vld_r) begin
            pend_r     <= 16'd0;
            pend_vld_r <= 1'b0;
          end else begin
            pend_r     <= hit_half;
            pend_vld_r <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emp_r <= 1'b0;
      hit_r <= 1'b0;
    end else if (cmd.load) begin
      emp_r <= plan_emp;
      hit_r <= plan_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      trl_word_r <= trl_word_nxt;
      hit_word_r <= hit_word_nxt;
      cur_r      <= start;
      stop_r     <= stop_nxt;
    end else if (cmd.emit && (cmd.sel == SEL_EMP)) begin
      cur_r <= cur_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      unique case (cmd.sel)
        SEL_TRL: begin
          out_word_r <= trl_word_r;
          out_last_r <= !emp_r && !hit_r;
        end
        SEL_EMP: begin
          out_word_r <= emp_word;
          out_last_r <= (cur_r == stop_r) && !hit_r;
        end
        SEL_HIT: begin
          out_word_r <= hit_word_r;
          out_last_r <= 1'b1;
        end
        default: begin
          out_word_r <= hit_word_r;
          out_last_r <= 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    stat.plan_trl = plan_trl;
    stat.plan_emp = plan_emp;
    stat.plan_hit = plan_hit;
    stat.emp_r    = emp_r;
    stat.hit_r    = hit_r;
    stat.emp_last = (cur_r == stop_r);
    stat.out_free = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_last  = out_last_r;

  a_pend_open: assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r |-> open_r)
    else $error("pending half held with no chip open");

  a_count_open: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != 12'd0) |-> open_r)
    else $error("hit count nonzero with no chip open");

  a_emp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && (cmd.sel == SEL_EMP)) |-> (cur_r <= stop_r) && (cur_r < 5'd16))
    else $error("empty chip emitted outside its range");

endmodule

// ===== sv/pcsf_ctrl.sv =====
module pcsf_ctrl
  import pcsf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_TRL  = 4'b0010,
    ST_EMP  = 4'b0100,
    ST_HIT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   load;

  assign in_ready = (state_r == ST_IDLE);
  assign load     = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (load) begin
          priority if (stat.plan_trl) state_nxt = ST_TRL;
          else if (stat.plan_emp)     state_nxt = ST_EMP;
          else if (stat.plan_hit)     state_nxt = ST_HIT;
          else                        state_nxt = ST_IDLE;
        end
      end
      ST_TRL: begin
        if (stat.out_free) begin
          priority if (stat.emp_r) state_nxt = ST_EMP;
          else if (stat.hit_r)     state_nxt = ST_HIT;
          else                     state_nxt = ST_IDLE;
        end
      end
      ST_EMP: begin
        if (stat.out_free && stat.emp_last) begin
          state_nxt = stat.hit_r ? ST_HIT : ST_IDLE;
        end
      end
      ST_HIT: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd.load = load;
    cmd.emit = (state_r != ST_IDLE) && stat.out_free;
    unique case (state_r)
      ST_TRL:  cmd.sel = SEL_TRL;
      ST_EMP:  cmd.sel = SEL_EMP;
      ST_HIT:  cmd.sel = SEL_HIT;
      default: cmd.sel = SEL_HIT;
    endcase
  end

  a_hit_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HIT && stat.out_free) |=> (state_r == ST_IDLE))
    else $error("sequence did not end after the hit word");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE && !stat.out_free) |=> $stable(state_r))
    else $error("sequencer advanced while the output was stalled");

endmodule
